[sv/clx_pkg.sv]
`timescale 1ns / 1ps
package clx_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int MAX_RES = 3;
  localparam int QUEUE_DEPTH = 8;
  localparam int QIDX_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [LENGTH_BITS-1:0] LEN_CAP =
    (LENGTH_BITS >= 16) ? LENGTH_BITS'(17'h0FFFF) : {LENGTH_BITS{1'b1}};

  localparam logic [63:0] MAX_DIV10 = 64'd1844674407370955161;
  localparam logic [63:0] MAX_MOD10 = 64'd5;

  localparam logic [47:0] KW_RETURN = 48'h6E7275746572;
  localparam logic [47:0] KW_ELSE = 48'h000065736C65;
  localparam logic [47:0] KW_IF = 48'h000000006669;
  localparam logic [47:0] KW_FOR = 48'h000000726F66;

  typedef enum logic [2:0] {
    K_NUM = 3'd0,
    K_IDENT = 3'd1,
    K_KEY = 3'd2,
    K_PUNCT = 3'd3,
    K_SBYTE = 3'd4,
    K_STRING = 3'd5,
    K_END = 3'd6,
    K_ERR = 3'd7
  } kind_t;

  localparam logic [63:0] E_STRING = 64'd0;
  localparam logic [63:0] E_HEX = 64'd1;
  localparam logic [63:0] E_COMMENT = 64'd2;
  localparam logic [63:0] E_BYTE = 64'd3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic end_of_input;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [63:0] value;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [31:0] src_line;
    logic last_of_run;
  } result_t;

  function automatic result_t mk_res(kind_t k, logic [63:0] v,
                                     logic [OFFSET_BITS-1:0] s,
                                     logic [LENGTH_BITS-1:0] l, logic [31:0] ln);
    result_t r;
    r.kind = k;
    r.value = v;
    r.start_offset = 32'(s);
    r.token_length = 16'(l);
    r.src_line = ln;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return c >= 8'd33 && c <= 8'd126 && !is_digit(c) && !is_alpha(c);
  endfunction

  function automatic logic is_pair_first(logic [7:0] c);
    return c == 8'h3D || c == 8'h21 || c == 8'h3C || c == 8'h3E || c == 8'h2D;
  endfunction

  // Returns a valid flag above the four-bit digit value.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (is_digit(c)) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b0;
  endfunction

  function automatic logic [7:0] simple_escape(logic [7:0] c);
    case (c)
      8'h61: return 8'd7;
      8'h62: return 8'd8;
      8'h74: return 8'd9;
      8'h6E: return 8'd10;
      8'h76: return 8'd11;
      8'h66: return 8'd12;
      8'h72: return 8'd13;
      8'h65: return 8'd27;
      default: return c;
    endcase
  endfunction

endpackage

[sv/clx_front.sv]
`timescale 1ns / 1ps
module clx_front (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  clx_pkg::item_t item,
  output clx_pkg::result_t res [clx_pkg::MAX_RES],
  output logic [1:0] res_count
);
  import clx_pkg::*;

  typedef enum logic [12:0] {
    M_IDLE  = 13'b0000000000001,
    M_SLASH = 13'b0000000000010,
    M_LINE  = 13'b0000000000100,
    M_BLOCK = 13'b0000000001000,
    M_BSTAR = 13'b0000000010000,
    M_NUM   = 13'b0000000100000,
    M_IDENT = 13'b0000001000000,
    M_PUNCT = 13'b0000010000000,
    M_STR   = 13'b0000100000000,
    M_ESC   = 13'b0001000000000,
    M_OCT   = 13'b0010000000000,
    M_HEX1  = 13'b0100000000000,
    M_HEX   = 13'b1000000000000
  } mode_t;

  mode_t mode, mode_next;
  logic [7:0] pending_char, pending_char_next;
  logic [OFFSET_BITS-1:0] tok_start, tok_start_next;
  logic [LENGTH_BITS-1:0] tok_len, tok_len_next;
  logic [31:0] line_cnt, line_cnt_next;
  logic [OFFSET_BITS-1:0] byte_off, byte_off_next;
  logic [63:0] num_acc, num_acc_next;
  logic [7:0] esc_acc, esc_acc_next;
  logic [1:0] esc_digits, esc_digits_next;
  logic [47:0] ident_prefix, ident_prefix_next;
  logic [31:0] tok_line, tok_line_next;
  logic halt, halt_next;

  logic [7:0] c;
  logic [4:0] hv;
  logic do_idle, do_str;
  logic [63:0] kw_val;
  kind_t id_kind;
  logic [63:0] sum10;
  logic [1:0] n;

  always_comb begin
    kw_val = 64'd0;
    id_kind = K_IDENT;
    if (tok_len == LENGTH_BITS'(6) && ident_prefix == KW_RETURN) begin
      id_kind = K_KEY;
      kw_val = 64'd0;
    end else if (tok_len == LENGTH_BITS'(4) && ident_prefix == KW_ELSE) begin
      id_kind = K_KEY;
      kw_val = 64'd1;
    end else if (tok_len == LENGTH_BITS'(2) && ident_prefix == KW_IF) begin
      id_kind = K_KEY;
      kw_val = 64'd2;
    end else if (tok_len == LENGTH_BITS'(3) && ident_prefix == KW_FOR) begin
      id_kind = K_KEY;
      kw_val = 64'd3;
    end
  end

  always_comb begin
    c = item.char_byte;
    hv = hex_val(c);
    sum10 = (num_acc << 3) + (num_acc << 1) + 64'(c - 8'h30);
    mode_next = mode;
    pending_char_next = pending_char;
    tok_start_next = tok_start;
    tok_len_next = tok_len;
    line_cnt_next = line_cnt;
    byte_off_next = byte_off;
    num_acc_next = num_acc;
    esc_acc_next = esc_acc;
    esc_digits_next = esc_digits;
    ident_prefix_next = ident_prefix;
    tok_line_next = tok_line;
    halt_next = halt;
    do_idle = 1'b0;
    do_str = 1'b0;
    n = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end

    if (item.end_of_input) begin
      if (!halt) begin
        unique case (mode)
          M_SLASH: begin
            res[n] = mk_res(K_PUNCT, 64'h2F, tok_start, tok_len, tok_line);
            n = n + 2'd1;
          end
          M_NUM: begin
            res[n] = mk_res(K_NUM, num_acc, tok_start, tok_len, tok_line);
            n = n + 2'd1;
          end
          M_IDENT: begin
            res[n] = mk_res(id_kind, kw_val, tok_start, tok_len, tok_line);
            n = n + 2'd1;
          end
          M_PUNCT: begin
            res[n] = mk_res(K_PUNCT, 64'(pending_char), tok_start, tok_len, tok_line);
            n = n + 2'd1;
          end
          M_BLOCK, M_BSTAR: begin
            res[n] = mk_res(K_ERR, E_COMMENT, tok_start, tok_len, tok_line);
            n = n + 2'd1;
          end
          M_STR, M_ESC, M_OCT, M_HEX1, M_HEX: begin
            res[n] = mk_res(K_ERR, E_STRING, tok_start, tok_len, tok_line);
            n = n + 2'd1;
          end
          default: begin
          end
        endcase
      end
      res[n] = mk_res(K_END, 64'd0, byte_off, '0, line_cnt);
      n = n + 2'd1;
      mode_next = M_IDLE;
      pending_char_next = 8'd0;
      tok_start_next = '0;
      tok_len_next = '0;
      line_cnt_next = 32'd1;
      byte_off_next = '0;
      num_acc_next = 64'd0;
      esc_acc_next = 8'd0;
      esc_digits_next = 2'd0;
      ident_prefix_next = 48'd0;
      tok_line_next = 32'd1;
      halt_next = 1'b0;
    end else begin
      if (!halt) begin
        unique case (mode)
          M_IDLE: do_idle = 1'b1;
          M_SLASH: begin
            if (c == 8'h2F) begin
              mode_next = M_LINE;
            end else if (c == 8'h2A) begin
              if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
              mode_next = M_BLOCK;
            end else begin
              res[n] = mk_res(K_PUNCT, 64'h2F, tok_start, tok_len, tok_line);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_LINE: begin
            if (c == 8'h0A) mode_next = M_IDLE;
          end
          M_BLOCK, M_BSTAR: begin
            if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
            if (mode == M_BSTAR && c == 8'h2F) begin
              mode_next = M_IDLE;
            end else begin
              mode_next = (c == 8'h2A) ? M_BSTAR : M_BLOCK;
            end
          end
          M_NUM: begin
            if (is_digit(c)) begin
              if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
              if (num_acc > MAX_DIV10 ||
                  (num_acc == MAX_DIV10 && 64'(c - 8'h30) > MAX_MOD10)) begin
                num_acc_next = '1;
              end else begin
                num_acc_next = sum10;
              end
            end else begin
              res[n] = mk_res(K_NUM, num_acc, tok_start, tok_len, tok_line);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              if (tok_len < LENGTH_BITS'(6)) begin
                ident_prefix_next = ident_prefix | (48'(c) << {tok_len[2:0], 3'b000});
              end
              if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
            end else begin
              res[n] = mk_res(id_kind, kw_val, tok_start, tok_len, tok_line);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_PUNCT: begin
            if (c == ((pending_char == 8'h2D) ? 8'h3E : 8'h3D)) begin
              if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
              res[n] = mk_res(K_PUNCT, {48'd0, c, pending_char}, tok_start,
                              tok_len_next, tok_line);
              n = n + 2'd1;
              mode_next = M_IDLE;
            end else begin
              res[n] = mk_res(K_PUNCT, 64'(pending_char), tok_start, tok_len, tok_line);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_STR: do_str = 1'b1;
          M_ESC: begin
            if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
            if (c >= 8'h30 && c <= 8'h37) begin
              esc_acc_next = c - 8'h30;
              esc_digits_next = 2'd1;
              mode_next = M_OCT;
            end else if (c == 8'h78) begin
              esc_acc_next = 8'd0;
              mode_next = M_HEX1;
            end else begin
              res[n] = mk_res(K_SBYTE, 64'(simple_escape(c)), tok_start, '0, tok_line);
              n = n + 2'd1;
              mode_next = M_STR;
            end
          end
          M_OCT: begin
            if (c >= 8'h30 && c <= 8'h37) begin
              if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
              esc_acc_next = {esc_acc[4:0], 3'b000} + (c - 8'h30);
              esc_digits_next = esc_digits + 2'd1;
              if (esc_digits_next == 2'd3) begin
                res[n] = mk_res(K_SBYTE, 64'(esc_acc_next), tok_start, '0, tok_line);
                n = n + 2'd1;
                mode_next = M_STR;
              end
            end else begin
              res[n] = mk_res(K_SBYTE, 64'(esc_acc), tok_start, '0, tok_line);
              n = n + 2'd1;
              do_str = 1'b1;
            end
          end
          M_HEX1, M_HEX: begin
            if (hv[4]) begin
              if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
              esc_acc_next = {esc_acc[3:0], hv[3:0]};
              mode_next = M_HEX;
            end else if (mode == M_HEX1) begin
              res[n] = mk_res(K_ERR, E_HEX, tok_start, tok_len, tok_line);
              n = n + 2'd1;
              halt_next = 1'b1;
              mode_next = M_IDLE;
            end else begin
              res[n] = mk_res(K_SBYTE, 64'(esc_acc), tok_start, '0, tok_line);
              n = n + 2'd1;
              do_str = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase

        if (do_idle) begin
          mode_next = M_IDLE;
          if (!is_space(c)) begin
            if (c == 8'h2F || is_digit(c) || c == 8'h22 || is_alpha(c) ||
                is_pair_first(c) || is_punct(c)) begin
              tok_start_next = byte_off;
              tok_line_next = line_cnt;
              tok_len_next = LENGTH_BITS'(1);
            end
            if (c == 8'h2F) begin
              mode_next = M_SLASH;
            end else if (is_digit(c)) begin
              mode_next = M_NUM;
              num_acc_next = 64'(c - 8'h30);
            end else if (c == 8'h22) begin
              mode_next = M_STR;
            end else if (is_alpha(c)) begin
              mode_next = M_IDENT;
              ident_prefix_next = 48'(c);
            end else if (is_pair_first(c)) begin
              mode_next = M_PUNCT;
              pending_char_next = c;
            end else if (is_punct(c)) begin
              res[n] = mk_res(K_PUNCT, 64'(c), byte_off, LENGTH_BITS'(1), line_cnt);
              n = n + 2'd1;
            end else begin
              res[n] = mk_res(K_ERR, E_BYTE, byte_off, LENGTH_BITS'(1), line_cnt);
              n = n + 2'd1;
            end
          end
        end

        if (do_str) begin
          mode_next = M_STR;
          if (c == 8'h22) begin
            if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
            res[n] = mk_res(K_STRING, 64'd0, tok_start, tok_len_next, tok_line);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (c == 8'h0A) begin
            res[n] = mk_res(K_ERR, E_STRING, tok_start, tok_len_next, tok_line);
            n = n + 2'd1;
            halt_next = 1'b1;
            mode_next = M_IDLE;
          end else if (c == 8'h5C) begin
            if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
            mode_next = M_ESC;
          end else begin
            if (tok_len_next < LEN_CAP) tok_len_next = tok_len_next + 1'b1;
            res[n] = mk_res(K_SBYTE, 64'(c), tok_start, '0, tok_line);
            n = n + 2'd1;
          end
        end
      end
      if (c == 8'h0A && line_cnt != 32'hFFFFFFFF) begin
        line_cnt_next = line_cnt + 32'd1;
      end
      byte_off_next = byte_off + 1'b1;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last_of_run = 1'b1;
    end
    res_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pending_char <= 8'd0;
      tok_start <= '0;
      tok_len <= '0;
      line_cnt <= 32'd1;
      byte_off <= '0;
      num_acc <= 64'd0;
      esc_acc <= 8'd0;
      esc_digits <= 2'd0;
      ident_prefix <= 48'd0;
      tok_line <= 32'd1;
      halt <= 1'b0;
    end else if (take) begin
      mode <= mode_next;
      pending_char <= pending_char_next;
      tok_start <= tok_start_next;
      tok_len <= tok_len_next;
      line_cnt <= line_cnt_next;
      byte_off <= byte_off_next;
      num_acc <= num_acc_next;
      esc_acc <= esc_acc_next;
      esc_digits <= esc_digits_next;
      ident_prefix <= ident_prefix_next;
      tok_line <= tok_line_next;
      halt <= halt_next;
    end
  end

endmodule

[sv/clx_queue.sv]
`timescale 1ns / 1ps
module clx_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  clx_pkg::result_t wr_data [clx_pkg::MAX_RES],
  input  logic [1:0] wr_count,
  output logic no_room,
  input  logic pop,
  output logic empty,
  output clx_pkg::result_t result
);
  import clx_pkg::*;

  result_t mem [QUEUE_DEPTH];
  logic [QIDX_BITS-1:0] wp, rp;
  logic [QIDX_BITS:0] cnt, cnt_next;
  logic [1:0] added;
  logic taken;

  assign empty = (cnt == '0);
  assign no_room = (cnt > (QIDX_BITS + 1)'(QUEUE_DEPTH - MAX_RES));
  assign result = mem[rp];
  assign added = wr ? wr_count : 2'd0;
  assign taken = pop && !empty;
  assign cnt_next = cnt + (QIDX_BITS + 1)'(added) - (QIDX_BITS + 1)'(taken);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < added) begin
        mem[wp + QIDX_BITS'(i)] <= wr_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      wp <= wp + QIDX_BITS'(added);
      if (taken) rp <= rp + 1'b1;
      cnt <= cnt_next;
    end
  end

endmodule

[sv/c_like_source_lexer_top.sv]
`timescale 1ns / 1ps
// One source byte is taken every cycle while the result queue has room for three results.
// A byte's results enter the eight-entry result queue at the edge accepting it; the first
// shows on the result ports in the next cycle if it was empty. One leaves per cycle on pop.
// Reset clears the scanner state and empties the queue, with no clearing pass.
module c_like_source_lexer_top (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  clx_pkg::item_t item,
  input  logic pop,
  output logic empty,
  output clx_pkg::result_t result
);
  import clx_pkg::*;

  result_t res [MAX_RES];
  logic [1:0] res_count;
  logic take;

  assign take = push && !full;

  clx_front u_front (
    .clk(clk),
    .rst(rst),
    .take(take),
    .item(item),
    .res(res),
    .res_count(res_count)
  );

  clx_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr(take),
    .wr_data(res),
    .wr_count(res_count),
    .no_room(full),
    .pop(pop),
    .empty(empty),
    .result(result)
  );

endmodule

[dv/c_like_source_lexer_top_tb.sv]
`timescale 1ns / 1ps
module c_like_source_lexer_top_tb;
  import clx_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SLASH, S_LINE, S_BLOCK, S_BSTAR, S_NUM, S_IDENT, S_PUNCT,
    S_STR, S_ESC, S_OCT, S_HEX1, S_HEX
  } lex_mode_t;

  localparam int LIMIT_CYCLES = 400000;

  logic clk;
  logic rst;
  logic push;
  logic full;
  item_t item;
  logic pop;
  logic empty;
  result_t result;

  c_like_source_lexer_top dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .pop(pop),
    .empty(empty),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Lexer state mirrored by the testbench.
  lex_mode_t mode;
  logic [7:0] pend_ch;
  logic [31:0] tok_start;
  logic [15:0] tok_len;
  logic [31:0] cur_line;
  logic [31:0] cur_off;
  logic [63:0] num_val;
  logic [7:0] esc_val;
  logic [1:0] esc_cnt;
  logic [47:0] id_text;
  logic [31:0] tok_line;
  logic halted;

  result_t token_queue[$];
  result_t step_out[$];
  int errors;
  int requests_sent;
  int tokens_checked;
  int cycles;
  int pop_hold;
  bit long_gaps;

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  task automatic lexer_clear();
    mode = S_IDLE;
    pend_ch = '0;
    tok_start = '0;
    tok_len = '0;
    cur_line = 32'd1;
    cur_off = '0;
    num_val = '0;
    esc_val = '0;
    esc_cnt = '0;
    id_text = '0;
    tok_line = 32'd1;
    halted = 1'b0;
  endtask

  task automatic put(kind_t k, logic [63:0] v, logic [31:0] s, logic [15:0] l,
                     logic [31:0] ln);
    result_t r;
    r.kind = k;
    r.value = v;
    r.start_offset = s;
    r.token_length = l;
    r.src_line = ln;
    r.last_of_run = 1'b0;
    if (step_out.size() < 3) step_out = {step_out, r};
  endtask

  task automatic put_tok(kind_t k, logic [63:0] v);
    put(k, v, tok_start, tok_len, tok_line);
  endtask

  task automatic grow();
    if (tok_len < 16'hFFFF) tok_len++;
  endtask

  task automatic open_tok(lex_mode_t m);
    mode = m;
    tok_start = cur_off;
    tok_line = cur_line;
    tok_len = 16'd1;
  endtask

  task automatic put_ident();
    logic [47:0] kw[4];
    int klen[4];
    kw = '{48'h6E7275746572, 48'h65736C65, 48'h6669, 48'h726F66};
    klen = '{6, 4, 2, 3};
    for (int k = 0; k < 4; k++) begin
      if (tok_len == klen[k] && id_text == kw[k]) begin
        put_tok(K_KEY, k);
        return;
      end
    end
    put_tok(K_IDENT, 0);
  endtask

  task automatic halt_err(logic [63:0] code);
    put_tok(K_ERR, code);
    halted = 1'b1;
    mode = S_IDLE;
  endtask

  task automatic lex_idle(logic [7:0] c);
    mode = S_IDLE;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (c == "/") begin
      open_tok(S_SLASH);
    end else if (dig(c)) begin
      open_tok(S_NUM);
      num_val = c - "0";
    end else if (c == "\"") begin
      open_tok(S_STR);
    end else if (alpha(c)) begin
      open_tok(S_IDENT);
      id_text = c;
    end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "-") begin
      open_tok(S_PUNCT);
      pend_ch = c;
    end else if (c >= 8'd33 && c <= 8'd126) begin
      open_tok(S_IDLE);
      put_tok(K_PUNCT, c);
    end else begin
      put(K_ERR, E_BYTE, cur_off, 16'd1, cur_line);
    end
  endtask

  task automatic lex_string(logic [7:0] c);
    mode = S_STR;
    if (c == "\"") begin
      grow();
      put_tok(K_STRING, 0);
      mode = S_IDLE;
    end else if (c == 8'h0A) begin
      halt_err(E_STRING);
    end else if (c == "\\") begin
      grow();
      mode = S_ESC;
    end else begin
      grow();
      put(K_SBYTE, c, tok_start, 16'd0, tok_line);
    end
  endtask

  function automatic logic [7:0] esc_char(logic [7:0] c);
    case (c)
      "a": return 8'd7;
      "b": return 8'd8;
      "t": return 8'd9;
      "n": return 8'd10;
      "v": return 8'd11;
      "f": return 8'd12;
      "r": return 8'd13;
      "e": return 8'd27;
      default: return c;
    endcase
  endfunction

  task automatic lex_byte(logic [7:0] c);
    int h;
    case (mode)
      S_IDLE: lex_idle(c);
      S_SLASH: begin
        if (c == "/") begin
          mode = S_LINE;
        end else if (c == "*") begin
          grow();
          mode = S_BLOCK;
        end else begin
          put_tok(K_PUNCT, "/");
          lex_idle(c);
        end
      end
      S_LINE: if (c == 8'h0A) mode = S_IDLE;
      S_BLOCK, S_BSTAR: begin
        grow();
        if (mode == S_BSTAR && c == "/") mode = S_IDLE;
        else mode = (c == "*") ? S_BSTAR : S_BLOCK;
      end
      S_NUM: begin
        if (dig(c)) begin
          grow();
          if (num_val > 64'd1844674407370955161 ||
              (num_val == 64'd1844674407370955161 && c - "0" > 5))
            num_val = '1;
          else
            num_val = num_val * 10 + (c - "0");
        end else begin
          put_tok(K_NUM, num_val);
          lex_idle(c);
        end
      end
      S_IDENT: begin
        if (alpha(c) || dig(c)) begin
          if (tok_len < 6) id_text[8*tok_len +: 8] = c;
          grow();
        end else begin
          put_ident();
          lex_idle(c);
        end
      end
      S_PUNCT: begin
        if (c == ((pend_ch == "-") ? 8'h3E : 8'h3D)) begin
          grow();
          put_tok(K_PUNCT, {48'd0, c, pend_ch});
          mode = S_IDLE;
        end else begin
          put_tok(K_PUNCT, pend_ch);
          lex_idle(c);
        end
      end
      S_STR: lex_string(c);
      S_ESC: begin
        grow();
        if (c >= "0" && c <= "7") begin
          esc_val = c - "0";
          esc_cnt = 2'd1;
          mode = S_OCT;
        end else if (c == "x") begin
          esc_val = '0;
          mode = S_HEX1;
        end else begin
          put(K_SBYTE, esc_char(c), tok_start, 16'd0, tok_line);
          mode = S_STR;
        end
      end
      S_OCT: begin
        if (c >= "0" && c <= "7") begin
          grow();
          esc_val = {esc_val[4:0], 3'b0} + (c - "0");
          esc_cnt++;
          if (esc_cnt == 2'd3) begin
            put(K_SBYTE, esc_val, tok_start, 16'd0, tok_line);
            mode = S_STR;
          end
        end else begin
          put(K_SBYTE, esc_val, tok_start, 16'd0, tok_line);
          lex_string(c);
        end
      end
      default: begin
        h = -1;
        if (dig(c)) h = c - "0";
        else if (c >= "a" && c <= "f") h = c - "a" + 10;
        else if (c >= "A" && c <= "F") h = c - "A" + 10;
        if (h >= 0) begin
          grow();
          esc_val = {esc_val[3:0], 4'b0} + h;
          mode = S_HEX;
        end else if (mode == S_HEX1) begin
          halt_err(E_HEX);
        end else begin
          put(K_SBYTE, esc_val, tok_start, 16'd0, tok_line);
          lex_string(c);
        end
      end
    endcase
  endtask

  task automatic lex_flush();
    case (mode)
      S_SLASH: put_tok(K_PUNCT, "/");
      S_NUM: put_tok(K_NUM, num_val);
      S_IDENT: put_ident();
      S_PUNCT: put_tok(K_PUNCT, pend_ch);
      S_BLOCK, S_BSTAR: put_tok(K_ERR, E_COMMENT);
      S_STR, S_ESC, S_OCT, S_HEX1, S_HEX: put_tok(K_ERR, E_STRING);
      default: ;
    endcase
  endtask

  task automatic predict_tokens(item_t it);
    step_out.delete();
    if (it.end_of_input) begin
      if (!halted) lex_flush();
      put(K_END, 0, cur_off, 16'd0, cur_line);
      lexer_clear();
    end else begin
      if (!halted) lex_byte(it.char_byte);
      if (it.char_byte == 8'h0A && cur_line != '1) cur_line++;
      cur_off++;
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last_of_run = 1'b1;
    foreach (step_out[i]) token_queue = {token_queue, step_out[i]};
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if (long_gaps && $urandom_range(0, 15) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_byte(logic [7:0] c, logic eoi);
    item_t it;
    int g;
    it.char_byte = c;
    it.end_of_input = eoi;
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_tokens(it);
    requests_sent++;
    g = gap_len();
    if (g != 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic end_source();
    send_byte(8'h00, 1'b1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (token_queue.size() == 0) begin
          $error("unexpected result kind=%0d value=%0h", result.kind, result.value);
          errors++;
        end else begin
          result_t e;
          e = token_queue.pop_front();
          tokens_checked++;
          if (result.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, result.kind);
            errors++;
          end
          if (result.value !== e.value) begin
            $error("value exp %0h got %0h", e.value, result.value);
            errors++;
          end
          if (result.start_offset !== e.start_offset) begin
            $error("start_offset exp %0d got %0d", e.start_offset, result.start_offset);
            errors++;
          end
          if (result.token_length !== e.token_length) begin
            $error("token_length exp %0d got %0d", e.token_length, result.token_length);
            errors++;
          end
          if (result.src_line !== e.src_line) begin
            $error("src_line exp %0d got %0d", e.src_line, result.src_line);
            errors++;
          end
          if (result.last_of_run !== e.last_of_run) begin
            $error("last_of_run exp %0d got %0d", e.last_of_run, result.last_of_run);
            errors++;
          end
        end
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (long_gaps && $urandom_range(0, 39) == 0) begin
        pop_hold = $urandom_range(8, 30);
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("c_like_source_lexer_top_tb failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_text("return else if for ifx _a9 x");
    send_text("0 18446744073709551615 99999999999999999999 7");
    send_text("== != <= >= -> = ! < > - / ; {}");
    send_text("a//line\nb/*c*/d/* ** / x*/e\n");
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("\"ab\\n\\e\\q\\101\\18\\x4G\\x1FF\\\"\"");
    send_byte(8'hFF, 1'b0);
    send_text("\"");
    end_source();
    send_text("\"abc\nzz");
    end_source();
    send_text("\"\\xg\"");
    end_source();
    send_text("/* open");
    end_source();
    send_text("\"open\\x4");
    end_source();
    send_text("x /");
    end_source();
    send_text("42");
    end_source();
    send_text("//tail");
    end_source();
  endtask

  task automatic test_random();
    string pool[];
    pool = '{"return", "if", "for", "else", "abc_1", "Z", "123", "0",
             "18446744073709551616", "==", "->", "!=", "<=", ">", "-", "(", "/",
             " ", "\n", "\t", "//c\n", "/*x*/", "/**/", "\"s\\t\"", "\"\\x41z\"",
             "\"\\0\\777\"", "\"q\\\n\"", "\"x\""};
    while (requests_sent < 225) begin
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) begin
        end_source();
      end else if (r < 3) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_text(pool[$urandom_range(0, pool.size() - 1)]);
      end
    end
    end_source();
  endtask

  task automatic test_drain_pause();
    send_text("if (x >= 10) return y;");
    wait_drained();
    repeat (5) @(posedge clk);
    send_text("\"done\" 5");
    end_source();
  endtask

  initial begin
    errors = 0;
    requests_sent = 0;
    tokens_checked = 0;
    cycles = 0;
    pop_hold = 0;
    long_gaps = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    item = '0;
    lexer_clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    long_gaps = 1'b1;
    test_random();
    test_drain_pause();
    long_gaps = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d source bytes and end marks; checked %0d tokens.",
             requests_sent, tokens_checked);
    if (errors == 0 && token_queue.size() == 0) begin
      $display("c_like_source_lexer_top_tb passed");
    end else begin
      $display("c_like_source_lexer_top_tb failed");
    end
    $finish;
  end

endmodule
